[src/rotary_position_embedding_defines.svh]
// Assertion macros for the rotary position embedding top level.
`ifndef ROTARY_POSITION_EMBEDDING_DEFINES_SVH
`define ROTARY_POSITION_EMBEDDING_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ROPE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ROPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rope_pkg.sv]
// Types, constants and table functions for the rotary position embedding block.
package rope_pkg;

  localparam int unsigned HeadSizeDef    = 64;
  localparam int unsigned CordicStepsDef = 16;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned SeqLenW   = 16;
  localparam int unsigned HeadCntW  = 7;
  localparam int unsigned HeadIdxW  = 6;
  localparam int unsigned PhaseW    = 32;
  localparam int unsigned FreqW     = 32;
  localparam int unsigned CsW       = 34;
  localparam int unsigned ProdW     = SampleW + CsW;
  localparam int unsigned AccW      = ProdW + 1;
  localparam int unsigned CfgAddrW  = 1;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned MaxHeads  = 64;
  localparam int unsigned MaxPairs  = 256;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  localparam logic [63:0] Inv2PiQ32  = 64'd683565276;
  localparam logic [63:0] Ln2Q32     = 64'd2977044472;
  localparam logic [63:0] Log21e4Q32 = 64'd57070290109;
  localparam logic signed [CsW-1:0] GainQ30 = CsW'(652032874);

  typedef enum logic [CfgAddrW-1:0] {
    CfgSeqLen    = 1'b0,
    CfgHeadCount = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [SeqLenW-1:0]  seq_len;
    logic [HeadCntW-1:0] head_count;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Packed so that q_even sits in the lowest bits.
  typedef struct packed {
    logic signed [SampleW-1:0] k_odd;
    logic signed [SampleW-1:0] k_even;
    logic signed [SampleW-1:0] q_odd;
    logic signed [SampleW-1:0] q_even;
  } sample_set_t;

  typedef struct packed {
    sample_set_t          samples;
    logic [SeqLenW-1:0]   position;
    logic [FreqW-1:0]     freq;
    logic                 done;
  } job_t;

  typedef struct packed {
    logic                      done;
    logic signed [SampleW-1:0] k_odd_rot;
    logic signed [SampleW-1:0] k_even_rot;
    logic signed [SampleW-1:0] q_odd_rot;
    logic signed [SampleW-1:0] q_even_rot;
  } result_t;

  // Shift-and-subtract quotient, used only while building the constant tables.
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Phase increment per position for pair d, in 32-bit fractions of a turn.
  function automatic logic [FreqW-1:0] freq_entry(input int unsigned d,
                                                  input int unsigned head_size);
    logic [63:0] hs;
    logic [63:0] e;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] m;
    logic [63:0] prod;
    hs = 64'(head_size);
    if (hs == 64'd0) begin
      hs = 64'd1;
    end
    e   = udiv(64'(d) * 64'd2 * Log21e4Q32 + (hs >> 1), hs);
    n   = e >> 32;
    f   = e & 64'hFFFF_FFFF;
    y   = (f * Ln2Q32 + 64'h8000_0000) >> 32;
    t   = 64'd1 << 32;
    pos = t;
    neg = '0;
    for (int k = 1; k <= 24; k++) begin
      t = udiv((t * y) >> 32, 64'(k));
      if ((k & 1) != 0) begin
        neg = neg + t;
      end else begin
        pos = pos + t;
      end
    end
    m = pos - neg;
    if (n > 64'd20) begin
      n = 64'd20;
    end
    prod = Inv2PiQ32 * m;
    return FreqW'((prod + (64'd1 << (31 + n))) >> (32 + n));
  endfunction

  // Arctangent of 2^-i in 32-bit fractions of a turn.
  function automatic logic [PhaseW-1:0] atan_entry(input int unsigned i);
    logic [63:0] p;
    logic [63:0] ps;
    logic [63:0] ns;
    logic [63:0] rad;
    logic [63:0] rq;
    logic [63:0] dv;
    logic        plus;
    p    = 64'd1 << (62 - i);
    ps   = '0;
    ns   = '0;
    dv   = 64'd1;
    plus = 1'b1;
    if (i == 0) begin
      return PhaseW'(64'd1 << 29);
    end
    while (p != 64'd0) begin
      if (plus) begin
        ps = ps + udiv(p, dv);
      end else begin
        ns = ns + udiv(p, dv);
      end
      plus = !plus;
      dv   = dv + 64'd2;
      p    = p >> (2 * i);
    end
    rad = ps - ns;
    rq  = (rad + (64'd1 << 29)) >> 30;
    return PhaseW'((rq * Inv2PiQ32 + 64'h8000_0000) >> 32);
  endfunction

endpackage

[src/rotary_position_embedding.sv]
// Top level of the rotary position embedding block: channels, configuration and output register.
//
// Each beat on the slave stream carries one interleaved query pair and one key pair, in
// tensor order with the pair index innermost, then position, then head. Both pairs are
// rotated by position * 10000^(-2*pair/HEAD_SIZE) radians and leave on the master stream,
// one result beat per input beat, in order; tlast marks the last pair of the tensor.
// The configuration channel (always ready) writes sequence_length at index 0 and
// head_count at index 1; write it only while no beat is in flight.
// In the rotation engine an item passes a phase multiply, a quadrant reduction, the
// CORDIC iterations at one iteration per cycle, a quadrant select and the
// rotate-and-round steps on one pair of multipliers, then waits until the result
// register takes it. Items are worked one at a time: the engine takes no new beat
// before the last one has left it for the result register.
// A two-entry queue behind the front end takes further beats while the engine is busy,
// and a result register lets the engine finish while the receiver stalls; with the
// receiver stalled, the queue fills and tready drops. Reset clears the counters, the
// queue and the valid flag of the result register and sets both configuration registers to one.
`include "rotary_position_embedding_defines.svh"

module rotary_position_embedding #(
  parameter int unsigned HEAD_SIZE    = rope_pkg::HeadSizeDef,
  parameter int unsigned CORDIC_STEPS = rope_pkg::CordicStepsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rope_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [rope_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // q_even [15:0], q_odd [31:16], k_even [47:32], k_odd [63:48]
  input  logic [63:0]                   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // q_even_rot [15:0], q_odd_rot [31:16], k_even_rot [47:32], k_odd_rot [63:48]
  output logic [63:0]                   m_axis_tdata_o,
  output logic                          m_axis_tlast_o
);

  rope_pkg::cfg_t        cfg_q, cfg_d;
  rope_pkg::queue_stat_t q_stat;
  rope_pkg::job_t        push_job, pop_job;
  rope_pkg::result_t     res, out_q;
  logic                  push, pop, back_ready, res_valid, res_ready;
  logic                  out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (rope_pkg::cfg_reg_e'(cfg_addr_i))
        rope_pkg::CfgSeqLen:    cfg_d.seq_len    = cfg_data_i;
        rope_pkg::CfgHeadCount: cfg_d.head_count = cfg_data_i[rope_pkg::HeadCntW-1:0];
        default: ;
      endcase
    end
  end

  rope_front #(
    .HEAD_SIZE (HEAD_SIZE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (rope_pkg::sample_set_t'(s_axis_tdata_i)),
    .stat_i     (q_stat),
    .push_o     (push),
    .job_o      (push_job)
  );

  rope_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (pop_job),
    .stat_o (q_stat)
  );

  assign pop = !q_stat.empty && back_ready;

  rope_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!q_stat.empty),
    .in_ready_o  (back_ready),
    .job_i       (pop_job),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // The result register frees up in the same cycle as its beat is taken.
  assign res_ready   = !out_valid_q || m_axis_tready_i;
  assign out_valid_d = (res_valid && res_ready) || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seq_len    <= rope_pkg::SeqLenW'(1);
      cfg_q.head_count <= rope_pkg::HeadCntW'(1);
      out_valid_q      <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.k_odd_rot, out_q.k_even_rot, out_q.q_odd_rot,
                            out_q.q_even_rot};
  assign m_axis_tlast_o  = out_q.done;

  `ROPE_ASSERT_NOW(a_push_has_room, clk_i, rst_ni, push, !q_stat.full, "push into a full queue")
  `ROPE_ASSERT_NOW(a_pop_has_job, clk_i, rst_ni, pop, !q_stat.empty, "pop from an empty queue")
  `ROPE_ASSERT_NEXT(a_back_busy, clk_i, rst_ni, pop, !back_ready, "engine took a second job")

endmodule

[src/rope_front.sv]
// Front end: accepts sample beats, tracks pair, position and head, looks up the frequency.
module rope_front #(
  parameter int unsigned HEAD_SIZE = rope_pkg::HeadSizeDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rope_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rope_pkg::sample_set_t in_data_i,
  input  rope_pkg::queue_stat_t stat_i,
  output logic                  push_o,
  output rope_pkg::job_t        job_o
);

  localparam int unsigned PairsRaw = HEAD_SIZE / 2;
  localparam int unsigned Pairs    = (PairsRaw < 1) ? 1 :
                                     ((PairsRaw > rope_pkg::MaxPairs) ? rope_pkg::MaxPairs
                                                                      : PairsRaw);
  localparam int unsigned PairIdxW = (Pairs > 1) ? $clog2(Pairs) : 1;

  logic [rope_pkg::FreqW-1:0] freq_tbl [Pairs];

  for (genvar g = 0; g < Pairs; g++) begin : g_freq
    localparam logic [rope_pkg::FreqW-1:0] Freq = rope_pkg::freq_entry(g, HEAD_SIZE);
    assign freq_tbl[g] = Freq;
  end

  logic [PairIdxW-1:0]            pair_q, pair_d;
  logic [rope_pkg::SeqLenW-1:0]   pos_q, pos_d;
  logic [rope_pkg::HeadIdxW-1:0]  head_q, head_d;
  logic [rope_pkg::HeadCntW-1:0]  heads;
  logic                           last_pair, last_pos, last_head, accept;

  assign in_ready_o = !stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  // A register value of zero behaves as one, a head count above the limit as the limit.
  assign heads     = (cfg_i.head_count > rope_pkg::HeadCntW'(rope_pkg::MaxHeads))
                     ? rope_pkg::HeadCntW'(rope_pkg::MaxHeads) : cfg_i.head_count;
  assign last_pair = ({1'b0, pair_q} + (PairIdxW + 1)'(1)) >= (PairIdxW + 1)'(Pairs);
  assign last_pos  = ({1'b0, pos_q} + (rope_pkg::SeqLenW + 1)'(1))
                     >= {1'b0, cfg_i.seq_len};
  assign last_head = (head_q == {rope_pkg::HeadIdxW{1'b1}})
                  || (({1'b0, head_q} + rope_pkg::HeadCntW'(1)) >= heads);

  always_comb begin
    job_o.samples  = in_data_i;
    job_o.position = pos_q;
    job_o.freq     = freq_tbl[pair_q];
    job_o.done     = last_pair && last_pos && last_head;
  end

  always_comb begin
    pair_d = pair_q;
    pos_d  = pos_q;
    head_d = head_q;
    if (accept) begin
      if (!last_pair) begin
        pair_d = pair_q + PairIdxW'(1);
      end else begin
        pair_d = '0;
        if (!last_pos) begin
          pos_d = pos_q + rope_pkg::SeqLenW'(1);
        end else begin
          pos_d  = '0;
          head_d = last_head ? '0 : head_q + rope_pkg::HeadIdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q <= '0;
      pos_q  <= '0;
      head_q <= '0;
    end else begin
      pair_q <= pair_d;
      pos_q  <= pos_d;
      head_q <= head_d;
    end
  end

endmodule

[src/rope_queue.sv]
// Two-entry job queue between the front end and the rotation engine.
module rope_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rope_pkg::job_t        job_i,
  input  logic                  pop_i,
  output rope_pkg::job_t        job_o,
  output rope_pkg::queue_stat_t stat_o
);

  rope_pkg::job_t                  mem_q [rope_pkg::QueueDepth];
  logic [rope_pkg::QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [rope_pkg::QueueCntW-1:0]  cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == rope_pkg::QueueCntW'(rope_pkg::QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign job_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + rope_pkg::QueuePtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + rope_pkg::QueuePtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + rope_pkg::QueueCntW'(push_i) - rope_pkg::QueueCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[src/rope_back.sv]
// Back end: phase, CORDIC sine and cosine, and rotation of the query and key pairs.
module rope_back #(
  parameter int unsigned CORDIC_STEPS = rope_pkg::CordicStepsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rope_pkg::job_t    job_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output rope_pkg::result_t res_o
);

  localparam int unsigned StepW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [StepW-1:0] LastStep = StepW'(CORDIC_STEPS - 1);
  localparam int unsigned CsW   = rope_pkg::CsW;
  localparam int unsigned AccW  = rope_pkg::AccW;
  localparam logic signed [AccW-1:0] RoundBias = AccW'(64'd1 << 29);
  localparam logic signed [AccW-1:0] SatHi     = AccW'(32767);
  localparam logic signed [AccW-1:0] SatLo     = AccW'(-32768);

  typedef enum logic [6:0] {
    BIdle  = 7'b0000001,
    BPhase = 7'b0000010,
    BQuad  = 7'b0000100,
    BIter  = 7'b0001000,
    BSel   = 7'b0010000,
    BRot   = 7'b0100000,
    BDone  = 7'b1000000
  } back_state_e;

  logic [rope_pkg::PhaseW-1:0] atan_tbl [CORDIC_STEPS];

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_atan
    localparam logic [rope_pkg::PhaseW-1:0] Atan = rope_pkg::atan_entry(g);
    assign atan_tbl[g] = Atan;
  end

  back_state_e                    state_q, state_d;
  logic [StepW-1:0]               step_q, step_d;
  logic [2:0]                     rot_q, rot_d;
  rope_pkg::job_t                 job_q;
  logic [rope_pkg::PhaseW-1:0]    phase_q;
  logic [1:0]                     quad_q;
  logic signed [CsW-1:0]          x_q, y_q, z_q, c_q, s_q;
  logic signed [AccW-1:0]         acc_q;
  rope_pkg::result_t              res_q;

  logic [rope_pkg::SeqLenW+rope_pkg::FreqW-1:0] phase_prod;
  logic [rope_pkg::PhaseW-1:0]    phase_bias, resid;
  logic [1:0]                     quad;
  logic signed [CsW-1:0]          x_sh, y_sh, at_ext;
  logic signed [rope_pkg::SampleW-1:0] op_e, op_o;
  logic signed [CsW-1:0]          op_p, op_r;
  logic signed [rope_pkg::ProdW-1:0]   m1, m2;
  logic signed [AccW-1:0]         acc, rnd, rnd_sh;
  logic signed [rope_pkg::SampleW-1:0] sat;

  assign in_ready_o  = (state_q == BIdle);
  assign res_valid_o = (state_q == BDone);
  assign res_o       = res_q;

  assign phase_prod = job_q.position * job_q.freq;

  // The residual angle is taken about the nearest quarter turn.
  assign phase_bias = phase_q + rope_pkg::PhaseW'(32'h2000_0000);
  assign quad       = phase_bias[rope_pkg::PhaseW-1 -: 2];
  assign resid      = phase_q - {quad, {(rope_pkg::PhaseW-2){1'b0}}};

  assign x_sh   = x_q >>> step_q;
  assign y_sh   = y_q >>> step_q;
  assign at_ext = $signed({{(CsW-rope_pkg::PhaseW){1'b0}}, atan_tbl[step_q]});

  // Even outputs take e*c - o*s, odd outputs take e*s + o*c.
  always_comb begin
    unique case (rot_q[1:0])
      2'd0: begin
        op_e = job_q.samples.q_even; op_o = job_q.samples.q_odd;
        op_p = c_q; op_r = s_q;
      end
      2'd1: begin
        op_e = job_q.samples.q_even; op_o = job_q.samples.q_odd;
        op_p = s_q; op_r = c_q;
      end
      2'd2: begin
        op_e = job_q.samples.k_even; op_o = job_q.samples.k_odd;
        op_p = c_q; op_r = s_q;
      end
      default: begin
        op_e = job_q.samples.k_even; op_o = job_q.samples.k_odd;
        op_p = s_q; op_r = c_q;
      end
    endcase
  end

  assign m1  = op_e * op_p;
  assign m2  = op_o * op_r;
  assign acc = rot_q[0] ? (AccW'(m2) + AccW'(m1)) : (AccW'(m1) - AccW'(m2));

  assign rnd    = acc_q + RoundBias;
  assign rnd_sh = rnd >>> 30;

  always_comb begin
    if (rnd_sh > SatHi) begin
      sat = SatHi[rope_pkg::SampleW-1:0];
    end else if (rnd_sh < SatLo) begin
      sat = SatLo[rope_pkg::SampleW-1:0];
    end else begin
      sat = rnd_sh[rope_pkg::SampleW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    rot_d   = rot_q;
    unique case (state_q)
      BIdle: begin
        if (in_valid_i) begin
          state_d = BPhase;
        end
      end
      BPhase: state_d = BQuad;
      BQuad: begin
        step_d  = '0;
        state_d = BIter;
      end
      BIter: begin
        if (step_q == LastStep) begin
          state_d = BSel;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      BSel: begin
        rot_d   = '0;
        state_d = BRot;
      end
      BRot: begin
        if (rot_q == 3'd4) begin
          state_d = BDone;
        end else begin
          rot_d = rot_q + 3'd1;
        end
      end
      BDone: begin
        if (res_ready_i) begin
          state_d = BIdle;
        end
      end
      default: state_d = BIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BIdle;
      step_q  <= '0;
      rot_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      rot_q   <= rot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BIdle: begin
        if (in_valid_i) begin
          job_q <= job_i;
        end
      end
      BPhase: phase_q <= phase_prod[rope_pkg::PhaseW-1:0];
      BQuad: begin
        quad_q <= quad;
        x_q    <= rope_pkg::GainQ30;
        y_q    <= '0;
        z_q    <= {{(CsW-rope_pkg::PhaseW){resid[rope_pkg::PhaseW-1]}}, resid};
      end
      BIter: begin
        if (!z_q[CsW-1]) begin
          x_q <= x_q - y_sh;
          y_q <= y_q + x_sh;
          z_q <= z_q - at_ext;
        end else begin
          x_q <= x_q + y_sh;
          y_q <= y_q - x_sh;
          z_q <= z_q + at_ext;
        end
      end
      BSel: begin
        unique case (quad_q)
          2'd0: begin c_q <= x_q;  s_q <= y_q;  end
          2'd1: begin c_q <= -y_q; s_q <= x_q;  end
          2'd2: begin c_q <= -x_q; s_q <= -y_q; end
          default: begin c_q <= y_q; s_q <= -x_q; end
        endcase
      end
      BRot: begin
        // Products for output n are summed in step n and rounded in step n+1.
        acc_q <= acc;
        unique case (rot_q)
          3'd1: res_q.q_even_rot <= sat;
          3'd2: res_q.q_odd_rot  <= sat;
          3'd3: res_q.k_even_rot <= sat;
          3'd4: res_q.k_odd_rot  <= sat;
          default: res_q.done    <= job_q.done;
        endcase
      end
      default: ;
    endcase
  end

endmodule
